// ----- design/mhpq_pkg.sv -----
package mhpq_pkg;

   localparam int MODE_W = 2;
   localparam int KEY_W  = 64;
   localparam int CNT_W  = 7;
   localparam int POS_W  = 8;
   localparam int REQ_W  = 72;
   localparam int RSP_W  = 80;

   localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH = 2'd0,
      MODE_POP  = 2'd1,
      MODE_PEEK = 2'd2
   } mode_type;

   typedef struct packed {
      logic take;
      logic push_start;
      logic root_rd;
      logic pop_load;
      logic peek_load;
      logic up_rd;
      logic up_step;
      logic dn_rd;
      logic dn_step;
      logic place;
      logic emit;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     can_push;
      logic     has_key;
      logic     at_root;
      logic     up_move;
      logic     dn_stop;
      logic     dn_move;
      logic     out_free;
   } status_type;

endpackage

// ----- design/mhpq_ram.sv -----
module mhpq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ----- design/mhpq_ctrl.sv -----
module mhpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mhpq_pkg::status_type status,
   output mhpq_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_DECODE  = 9'b000000010,
      ST_UP_RD   = 9'b000000100,
      ST_UP_CMP  = 9'b000001000,
      ST_POP_LD  = 9'b000010000,
      ST_DN_RD   = 9'b000100000,
      ST_DN_CMP  = 9'b001000000,
      ST_PEEK_LD = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            case (status.mode)
               mhpq_pkg::MODE_PUSH: begin
                  if (status.can_push) begin
                     cmd.push_start = 1'b1;
                     state_in       = ST_UP_RD;
                  end
               end
               mhpq_pkg::MODE_POP: begin
                  if (status.has_key) begin
                     cmd.root_rd = 1'b1;
                     state_in    = ST_POP_LD;
                  end
               end
               mhpq_pkg::MODE_PEEK: begin
                  if (status.has_key) begin
                     cmd.root_rd = 1'b1;
                     state_in    = ST_PEEK_LD;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_UP_RD: begin
            if (status.at_root) begin
               cmd.place = 1'b1;
               state_in  = ST_DONE;
            end else begin
               cmd.up_rd = 1'b1;
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            cmd.up_step = 1'b1;
            state_in    = status.up_move ? ST_UP_RD : ST_DONE;
         end
         ST_POP_LD: begin
            cmd.pop_load = 1'b1;
            state_in     = ST_DN_RD;
         end
         ST_DN_RD: begin
            if (status.dn_stop) begin
               cmd.place = 1'b1;
               state_in  = ST_DONE;
            end else begin
               cmd.dn_rd = 1'b1;
               state_in  = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            cmd.dn_step = 1'b1;
            state_in    = status.dn_move ? ST_DN_RD : ST_DONE;
         end
         ST_PEEK_LD: begin
            cmd.peek_load = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/mhpq_dpath.sv -----
module mhpq_dpath #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mhpq_pkg::REQ_W-1:0]        req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mhpq_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mhpq_pkg::CNT_W-1:0]        csr_data,
   input  mhpq_pkg::cmd_type                 cmd,
   output mhpq_pkg::status_type              status
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam logic [mhpq_pkg::CNT_W-1:0] DEPTH_CAP =
      (HEAP_DEPTH > 127) ? 7'd127 : mhpq_pkg::CNT_W'(HEAP_DEPTH);

   mhpq_pkg::mode_type             op_ff;
   logic [mhpq_pkg::KEY_W-1:0]     key_ff;
   logic [mhpq_pkg::CNT_W-1:0]     pos_ff;
   logic [mhpq_pkg::CNT_W-1:0]     count_ff;
   logic [mhpq_pkg::CNT_W-1:0]     cap_ff;
   logic                           ok_ff;
   logic [mhpq_pkg::KEY_W-1:0]     val_ff;
   logic                           rsp_valid_ff;
   logic [mhpq_pkg::RSP_W-1:0]     rsp_data_ff;

   logic [mhpq_pkg::CNT_W-1:0]     eff_cap;
   logic [mhpq_pkg::CNT_W-1:0]     parent;
   logic [mhpq_pkg::POS_W-1:0]     kid;
   logic [mhpq_pkg::POS_W-1:0]     kid_r;
   logic                           right_ok;
   logic                           pick_b;
   logic                           a_gt_key;
   logic                           b_gt_key;
   logic [mhpq_pkg::KEY_W-1:0]     kid_val;
   logic [mhpq_pkg::CNT_W-1:0]     kid_pos;
   logic                           full_now;

   logic [mhpq_pkg::POS_W-1:0]     ra_pos;
   logic [mhpq_pkg::POS_W-1:0]     rb_pos;
   logic [mhpq_pkg::POS_W-1:0]     ra_off;
   logic [mhpq_pkg::POS_W-1:0]     rb_off;
   logic [mhpq_pkg::POS_W-1:0]     wr_off;
   logic [AW-1:0]                  ra_addr;
   logic [AW-1:0]                  rb_addr;
   logic [AW-1:0]                  wr_addr;
   logic                           wr_en;
   logic [mhpq_pkg::KEY_W-1:0]     wr_data;
   logic [mhpq_pkg::KEY_W-1:0]     rd_a;
   logic [mhpq_pkg::KEY_W-1:0]     rd_b;

   assign eff_cap  = (cap_ff > DEPTH_CAP) ? DEPTH_CAP : cap_ff;
   assign parent   = pos_ff >> 1;
   assign kid      = {pos_ff, 1'b0};
   assign kid_r    = kid + 8'd1;
   assign right_ok = kid < {1'b0, count_ff};
   assign a_gt_key = rd_a > key_ff;
   assign b_gt_key = rd_b > key_ff;
   assign pick_b   = right_ok && (rd_b > rd_a);
   assign kid_val  = pick_b ? rd_b : rd_a;
   assign kid_pos  = pick_b ? kid_r[mhpq_pkg::CNT_W-1:0] : kid[mhpq_pkg::CNT_W-1:0];
   assign full_now = count_ff >= eff_cap;

   assign status.mode     = op_ff;
   assign status.can_push = count_ff < eff_cap;
   assign status.has_key  = count_ff != '0;
   assign status.at_root  = pos_ff == 7'd1;
   assign status.up_move  = rd_a < key_ff;
   assign status.dn_stop  = kid > {1'b0, count_ff};
   assign status.dn_move  = pick_b ? b_gt_key : a_gt_key;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // root and last entry on a pop or peek; parent on the way up; both children on the way down
   always_comb begin
      ra_pos = 8'd1;
      rb_pos = 8'd1;
      if (cmd.root_rd) begin
         rb_pos = {1'b0, count_ff};
      end else if (cmd.up_rd) begin
         ra_pos = {1'b0, parent};
      end else if (cmd.dn_rd) begin
         ra_pos = kid;
         rb_pos = kid_r;
      end
   end

   assign ra_off  = ra_pos - 8'd1;
   assign rb_off  = rb_pos - 8'd1;
   assign wr_off  = {1'b0, pos_ff} - 8'd1;
   assign ra_addr = AW'(ra_off);
   assign rb_addr = AW'(rb_off);
   assign wr_addr = AW'(wr_off);

   assign wr_en = cmd.up_step || cmd.dn_step || cmd.place;

   always_comb begin
      wr_data = key_ff;
      if (cmd.up_step && status.up_move) begin
         wr_data = rd_a;
      end else if (cmd.dn_step && status.dn_move) begin
         wr_data = kid_val;
      end
   end

   mhpq_ram #(
      .WIDTH (mhpq_pkg::KEY_W),
      .DEPTH (HEAP_DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (ra_addr),
      .rd_b_addr (rb_addr),
      .rd_a_data (rd_a),
      .rd_b_data (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= mhpq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
         if (cmd.push_start) begin
            count_ff <= count_ff + 7'd1;
         end else if (cmd.pop_load) begin
            count_ff <= count_ff - 7'd1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff  <= mhpq_pkg::mode_type'(req_tdata[mhpq_pkg::MODE_W-1:0]);
         key_ff <= req_tdata[mhpq_pkg::MODE_W +: mhpq_pkg::KEY_W];
         ok_ff  <= 1'b0;
         val_ff <= '0;
      end
      if (cmd.push_start) begin
         pos_ff <= count_ff + 7'd1;
         ok_ff  <= 1'b1;
      end
      if (cmd.pop_load) begin
         val_ff <= rd_a;
         key_ff <= rd_b;
         pos_ff <= 7'd1;
         ok_ff  <= 1'b1;
      end
      if (cmd.peek_load) begin
         val_ff <= rd_a;
         ok_ff  <= 1'b1;
      end
      if (cmd.up_step && status.up_move) begin
         pos_ff <= parent;
      end
      if (cmd.dn_step && status.dn_move) begin
         pos_ff <= kid_pos;
      end
      if (cmd.emit) begin
         rsp_data_ff <= {6'b0, !status.has_key, full_now, count_ff, val_ff, ok_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

// ----- design/max_heap_priority_queue.sv -----
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata: mode[1:0], key_value[65:2]
// rsp     | out | rsp_tvalid/rsp_tready | tdata: ok, result_value, element_count, is_full, is_empty
// csr     | in  | csr_valid/csr_ready   | csr_data: capacity_limit
//
// One request at a time, from acceptance through the emitted response. Refused or spare mode:
// decode, then done. Peek: decode with root read, load, done. Push/pop: decode (and a load
// for a pop), then per heap level the key moves a read, then a compare and write through the single RAM.
// rsp_tvalid rises at the edge where req_tready returns.
// Synchronous reset empties the queue and sets the capacity to 64; no store clearing.
// A waiting response holds while the next request is taken; that one waits until it leaves.
module max_heap_priority_queue #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [mhpq_pkg::REQ_W-1:0] req_tdata,  // mode[1:0], key_value[65:2], zero pad
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [mhpq_pkg::RSP_W-1:0] rsp_tdata,  // ok[0], result_value[64:1],
                                                  // element_count[71:65], is_full[72],
                                                  // is_empty[73], zero pad
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mhpq_pkg::CNT_W-1:0] csr_data
);

   mhpq_pkg::cmd_type    cmd;
   mhpq_pkg::status_type status;

   mhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mhpq_dpath #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ----- design/mhpq_checker.sv -----
module mhpq_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [mhpq_pkg::RSP_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[73] == (rsp_tdata[71:65] == 7'd0))
      else $error("empty flag disagrees with count");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[64:1] == 64'd0)
      else $error("refused request returned a key");

endmodule

bind max_heap_priority_queue mhpq_checker u_chk (.*);
